/* rtl/multichannel_alarm_timer_assert.svh */
// Assertion macros used by the timer bank's checker.
`ifndef MULTICHANNEL_ALARM_TIMER_ASSERT_SVH
`define MULTICHANNEL_ALARM_TIMER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define MAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define MAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mat_pkg.sv */
package mat_pkg;

    localparam int DEF_CHANNELS = 8;

    // Events reported per channel pass; later expiries still update state.
    localparam int MAX_EVENTS = 8;
    localparam int EVW        = $clog2(MAX_EVENTS + 1);

    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_PROC   = 3'd1;
    localparam logic [2:0] FN_TNP    = 3'd2;
    localparam logic [2:0] FN_CREATE = 3'd3;
    localparam logic [2:0] FN_DELETE = 3'd4;
    localparam logic [2:0] FN_START  = 3'd5;
    localparam logic [2:0] FN_STOP   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  channel;
        logic [31:0] alarm_value;
        logic        single_shot;
        logic        has_callback;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [2:0] fired_channel;
        logic [1:0] status;
        logic       any_active;
        logic [2:0] assigned_channel;
        logic       last;
    } t_out;

endpackage

/* rtl/multichannel_alarm_timer.sv */
// Bank of CHANNELS software timer channels driven by one command stream.
// Input channel: i_in_valid / o_in_ready carry one command (tick, process,
// tick_and_process, create, delete, start, stop) per transfer.
// Output channel: o_out_valid / i_out_ready carry result items. Every command
// ends with exactly one status result marked last; a process pass first
// sends one event per expired channel with a callback, up to MAX_EVENTS, in channel order.
// Sequencing: a tick or process command walks the channels one at a time
// through the shared counter/compare unit, a memory read state and then an
// update and write-back state per channel. A create scans the used flags
// one per cycle, or goes straight to its status result when the slot count
// is already at its limit. Delete, start and stop pass through one command
// state before their status result. The block takes one command at a time;
// o_in_ready is high only while no command is in progress.
// A stalled receiver holds the walk on the channel whose event cannot be
// delivered; the finished status result waits in the output register while
// the next command can already be accepted.
// Reset clears all channel flags, the slot count and the output valid flag.
module multichannel_alarm_timer #(
    parameter int CHANNELS = mat_pkg::DEF_CHANNELS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mat_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mat_pkg::t_out  o_out_data
);
    import mat_pkg::*;

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMD    = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_EX     = 3'd4;
    localparam logic [2:0] S_RES    = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [2:0]          r_func, n_func;
    logic [7:0]          r_chan, n_chan;
    logic [31:0]         r_alarm, n_alarm;
    logic                r_single, n_single;
    logic                r_notify, n_notify;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_any, n_any;
    logic [EVW-1:0]      r_nev, n_nev;
    logic [1:0]          r_status, n_status;
    logic [2:0]          r_asg, n_asg;
    logic [CHANNELS-1:0] r_used, n_used;
    logic [CHANNELS-1:0] r_run, n_run;
    logic [CHANNELS-1:0] r_oneshot, n_oneshot;
    logic [CHANNELS-1:0] r_cbk, n_cbk;
    logic [CW-1:0]       r_inuse, n_inuse;
    logic                r_ov, n_ov;
    t_out                r_od, n_od;

    // Channel value and alarm stores, one entry per channel.
    logic [31:0]         r_cnt_mem [CHANNELS];
    logic [31:0]         r_alm_mem [CHANNELS];
    logic [31:0]         r_cnt_rd;
    logic [31:0]         r_alm_rd;
    logic                mem_we_cnt;
    logic                mem_we_alm;
    logic [IW-1:0]       mem_wa;
    logic [31:0]         mem_wd_cnt;

    logic                out_free;
    logic                chan_ok;
    logic [IW-1:0]       chan_idx;
    logic                active;
    logic                do_tick;
    logic                do_chk;
    logic [31:0]         cnt_t;
    logic                expired;
    logic                report;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    assign out_free = !r_ov || i_out_ready;
    assign chan_ok  = (r_chan < 8'(CHANNELS));
    assign chan_idx = r_chan[IW-1:0];

    // Shared per-channel update unit: one channel's value and alarm per step.
    assign active  = r_used[r_idx] && r_run[r_idx];
    assign do_tick = (r_func != FN_PROC);
    assign do_chk  = (r_func != FN_TICK);
    assign cnt_t   = do_tick ? (r_cnt_rd + 32'd1) : r_cnt_rd;
    assign expired = active && do_chk && (r_alm_rd != 32'd0) && (cnt_t >= r_alm_rd);
    assign report  = expired && r_cbk[r_idx] && (r_nev < EVW'(MAX_EVENTS));

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_chan     = r_chan;
        n_alarm    = r_alarm;
        n_single   = r_single;
        n_notify   = r_notify;
        n_idx      = r_idx;
        n_any      = r_any;
        n_nev      = r_nev;
        n_status   = r_status;
        n_asg      = r_asg;
        n_used     = r_used;
        n_run      = r_run;
        n_oneshot  = r_oneshot;
        n_cbk      = r_cbk;
        n_inuse    = r_inuse;
        n_ov       = r_ov;
        n_od       = r_od;
        mem_we_cnt = 1'b0;
        mem_we_alm = 1'b0;
        mem_wa     = r_idx;
        mem_wd_cnt = 32'd0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func   = i_in_data.func;
                    n_chan   = i_in_data.channel;
                    n_alarm  = i_in_data.alarm_value;
                    n_single = i_in_data.single_shot;
                    n_notify = i_in_data.has_callback;
                    n_idx    = '0;
                    n_any    = 1'b0;
                    n_nev    = '0;
                    n_status = ST_OK;
                    n_asg    = 3'd0;
                    case (i_in_data.func)
                        FN_TICK, FN_PROC, FN_TNP: begin
                            n_state = S_RD;
                        end
                        FN_CREATE: begin
                            if (r_inuse >= CW'(CHANNELS)) begin
                                n_status = ST_FULL;
                                n_state  = S_RES;
                            end else begin
                                // The count rises even if the scan finds no free slot.
                                n_inuse = r_inuse + CW'(1);
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            n_state = S_CMD;
                        end
                    endcase
                end
            end
            S_CMD: begin
                case (r_func)
                    FN_DELETE: begin
                        if (!chan_ok) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_run[chan_idx]  = 1'b0;
                            n_used[chan_idx] = 1'b0;
                            if (r_inuse != '0) begin
                                n_inuse = r_inuse - CW'(1);
                            end
                        end
                    end
                    FN_START: begin
                        if (!chan_ok) begin
                            n_status = ST_RANGE;
                        end else if (r_used[chan_idx]) begin
                            mem_we_cnt      = 1'b1;
                            mem_wa          = chan_idx;
                            n_run[chan_idx] = 1'b1;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    FN_STOP: begin
                        if (!chan_ok) begin
                            n_status = ST_RANGE;
                        end else if (r_used[chan_idx]) begin
                            n_run[chan_idx] = 1'b0;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_RES;
            end
            S_SEARCH: begin
                if (!r_used[r_idx]) begin
                    n_used[r_idx]    = 1'b1;
                    n_run[r_idx]     = 1'b0;
                    n_oneshot[r_idx] = r_single;
                    n_cbk[r_idx]     = r_notify;
                    mem_we_cnt       = 1'b1;
                    mem_we_alm       = 1'b1;
                    n_asg            = 3'(r_idx);
                    n_status         = ST_OK;
                    n_state          = S_RES;
                end else if (r_idx == LAST_IDX) begin
                    n_status = ST_FULL;
                    n_state  = S_RES;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                // Hold on this channel while an event cannot enter the output register.
                if (!report || out_free) begin
                    if (active) begin
                        n_any      = 1'b1;
                        mem_we_cnt = 1'b1;
                        mem_wd_cnt = (expired && r_cbk[r_idx]) ? 32'd0 : cnt_t;
                    end
                    if (expired && r_oneshot[r_idx]) begin
                        n_run[r_idx] = 1'b0;
                    end
                    if (report) begin
                        n_ov                  = 1'b1;
                        n_od.kind             = KIND_EVENT;
                        n_od.fired_channel    = 3'(r_idx);
                        n_od.status           = ST_OK;
                        n_od.any_active       = 1'b0;
                        n_od.assigned_channel = 3'd0;
                        n_od.last             = 1'b0;
                        n_nev                 = r_nev + EVW'(1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_RES;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_ov                  = 1'b1;
                    n_od.kind             = KIND_STATUS;
                    n_od.fired_channel    = 3'd0;
                    n_od.status           = r_status;
                    n_od.any_active       = ((r_func == FN_PROC) || (r_func == FN_TNP))
                                            ? r_any : 1'b0;
                    n_od.assigned_channel = r_asg;
                    n_od.last             = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_run     <= '0;
            r_oneshot <= '0;
            r_cbk     <= '0;
            r_inuse   <= '0;
            r_ov      <= 1'b0;
            r_idx     <= '0;
            r_any     <= 1'b0;
            r_nev     <= '0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_run     <= n_run;
            r_oneshot <= n_oneshot;
            r_cbk     <= n_cbk;
            r_inuse   <= n_inuse;
            r_ov      <= n_ov;
            r_idx     <= n_idx;
            r_any     <= n_any;
            r_nev     <= n_nev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_chan   <= n_chan;
        r_alarm  <= n_alarm;
        r_single <= n_single;
        r_notify <= n_notify;
        r_status <= n_status;
        r_asg    <= n_asg;
        r_od     <= n_od;
    end

    // A channel's entries are always written by create or start before the
    // walk can see that channel running, so the stores need no clearing.
    always_ff @(posedge i_clk) begin
        if (mem_we_cnt) begin
            r_cnt_mem[mem_wa] <= mem_wd_cnt;
        end
        if (mem_we_alm) begin
            r_alm_mem[mem_wa] <= r_alarm;
        end
        r_cnt_rd <= r_cnt_mem[r_idx];
        r_alm_rd <= r_alm_mem[r_idx];
    end

endmodule

/* rtl/mat_checker.sv */
`include "multichannel_alarm_timer_assert.svh"

module mat_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input mat_pkg::t_out o_out_data
);
    import mat_pkg::*;

    `MAT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed or dropped while stalled")

    // Every command leaves the idle state when it is accepted, so a transfer always ends readiness.
    `MAT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready again right after a command transfer")

    `MAT_ASSERT_NOW(a_event_fields, o_out_valid && (o_out_data.kind == KIND_EVENT), !o_out_data.last && (o_out_data.status == ST_OK) && (o_out_data.assigned_channel == 3'd0), "event result with status fields set")

    `MAT_ASSERT_NOW(a_status_last, o_out_valid && (o_out_data.kind == KIND_STATUS), o_out_data.last && (o_out_data.fired_channel == 3'd0), "status result not marked last")

endmodule

bind multichannel_alarm_timer mat_checker u_mat_checker (.*);
